>>> hw/rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants
// Default parameter values and the sideband record that travels alongside the
// divider lanes of the ray/box slab test.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PAR_THRESH_DEF = 1;

    // Width of the unsigned fraction fields.
    localparam int FRAC_W = 31;

    // Number of divider lanes: lower and upper face for x, then for y.
    localparam int LANES   = 4;
    localparam int LANE_LX = 0;
    localparam int LANE_HX = 1;
    localparam int LANE_LY = 2;
    localparam int LANE_HY = 3;

    // Per-item control that rides along the divider pipeline.
    typedef struct packed {
        logic [LANES-1:0]  neg;       // quotient of this lane is negative
        logic              par_x;     // x direction below threshold
        logic              par_y;     // y direction below threshold
        logic              par_miss;  // start outside a parallel slab
        logic [FRAC_W-1:0] max_frac;  // largest accepted entry fraction
    } t_side;

endpackage

>>> hw/rtl/aabb_ray_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// aabb_ray_slab_intersect_top: 2D ray versus box slab test
// Fixed-point Q16.16 slab test returning hit, entry fraction and face normal.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock and returns one result per
// transaction, in order, after one operand stage, one restoring divider
// stage per quotient bit for the four face fractions, and two stages that
// saturate, merge the axes and register the result. The whole pipeline
// advances whenever the output register is empty or its result is being
// taken, so a stalled output holds every transaction in flight in place.
module aabb_ray_slab_intersect_top
    import aabb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PAR_THRESH = PAR_THRESH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_box_lo_x,
    input  logic signed [COORD_BITS-1:0]  i_box_lo_y,
    input  logic signed [COORD_BITS-1:0]  i_box_hi_x,
    input  logic signed [COORD_BITS-1:0]  i_box_hi_y,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_y,
    input  logic [FRAC_W-1:0]             i_max_fraction,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [FRAC_W-1:0]             o_fraction,
    output logic signed [1:0]             o_normal_x,
    output logic signed [1:0]             o_normal_y
);

    localparam int NW = COORD_BITS + FRAC_BITS;

    logic                               en;
    logic                               prep_valid;
    logic [LANES-1:0][NW-1:0]           prep_num;
    logic [LANES-1:0][COORD_BITS-1:0]   prep_den;
    t_side                              prep_side;
    logic                               div_valid;
    logic [LANES-1:0][NW-1:0]           div_quo;
    t_side                              div_side;

    // The pipeline moves unless a finished result is waiting to be taken.
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    aabb_prep #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .PAR_THRESH (PAR_THRESH)
    ) u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_valid),
        .i_box_lo_x     (i_box_lo_x),
        .i_box_lo_y     (i_box_lo_y),
        .i_box_hi_x     (i_box_hi_x),
        .i_box_hi_y     (i_box_hi_y),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_max_fraction (i_max_fraction),
        .o_valid        (prep_valid),
        .o_num          (prep_num),
        .o_den          (prep_den),
        .o_side         (prep_side)
    );

    aabb_div_pipe #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_valid),
        .i_num   (prep_num),
        .i_den   (prep_den),
        .i_side  (prep_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    aabb_resolve #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_resolve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (div_valid),
        .i_quo      (div_quo),
        .i_side     (div_side),
        .o_valid    (o_valid),
        .o_hit      (o_hit),
        .o_fraction (o_fraction),
        .o_normal_x (o_normal_x),
        .o_normal_y (o_normal_y)
    );

endmodule

>>> hw/rtl/aabb_prep.sv
// ----------------------------------------------------------------------------
// aabb_prep: operand preparation stage
// Forms direction and face offsets, their magnitudes and signs, the parallel
// slab checks, and registers the divider operands.
// ----------------------------------------------------------------------------
module aabb_prep
    import aabb_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int PAR_THRESH   = PAR_THRESH_DEF,
    localparam int NW          = COORD_BITS + FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [COORD_BITS-1:0]       i_box_lo_x,
    input  logic signed [COORD_BITS-1:0]       i_box_lo_y,
    input  logic signed [COORD_BITS-1:0]       i_box_hi_x,
    input  logic signed [COORD_BITS-1:0]       i_box_hi_y,
    input  logic signed [COORD_BITS-1:0]       i_start_x,
    input  logic signed [COORD_BITS-1:0]       i_start_y,
    input  logic signed [COORD_BITS-1:0]       i_end_x,
    input  logic signed [COORD_BITS-1:0]       i_end_y,
    input  logic [FRAC_W-1:0]                  i_max_fraction,
    output logic                               o_valid,
    output logic [LANES-1:0][NW-1:0]           o_num,
    output logic [LANES-1:0][COORD_BITS-1:0]   o_den,
    output t_side                              o_side
);

    localparam int W = COORD_BITS;

    logic                         r_valid;
    logic [LANES-1:0][NW-1:0]     r_num;
    logic [LANES-1:0][W-1:0]      r_den;
    t_side                        r_side;

    logic [LANES-1:0][NW-1:0]     n_num;
    logic [LANES-1:0][W-1:0]      n_den;
    t_side                        n_side;

    logic signed [W:0] dx, dy;
    logic signed [W:0] f_lx, f_hx, f_ly, f_hy;
    logic [W-1:0]      mag_dx, mag_dy;
    logic [W-1:0]      mag_lx, mag_hx, mag_ly, mag_hy;
    logic              par_x, par_y;
    logic              out_x, out_y;

    // Differences are taken one bit wider so they never overflow.
    assign dx   = $signed({i_end_x[W-1], i_end_x}) - $signed({i_start_x[W-1], i_start_x});
    assign dy   = $signed({i_end_y[W-1], i_end_y}) - $signed({i_start_y[W-1], i_start_y});
    assign f_lx = $signed({i_box_lo_x[W-1], i_box_lo_x})
                - $signed({i_start_x[W-1], i_start_x});
    assign f_hx = $signed({i_box_hi_x[W-1], i_box_hi_x})
                - $signed({i_start_x[W-1], i_start_x});
    assign f_ly = $signed({i_box_lo_y[W-1], i_box_lo_y})
                - $signed({i_start_y[W-1], i_start_y});
    assign f_hy = $signed({i_box_hi_y[W-1], i_box_hi_y})
                - $signed({i_start_y[W-1], i_start_y});

    // Magnitudes fit in W bits since each difference stays below 2^W.
    assign mag_dx = W'(dx[W] ? -dx : dx);
    assign mag_dy = W'(dy[W] ? -dy : dy);
    assign mag_lx = W'(f_lx[W] ? -f_lx : f_lx);
    assign mag_hx = W'(f_hx[W] ? -f_hx : f_hx);
    assign mag_ly = W'(f_ly[W] ? -f_ly : f_ly);
    assign mag_hy = W'(f_hy[W] ? -f_hy : f_hy);

    // Parallel axes only check that the start lies inside the slab.
    assign par_x = {9'd0, mag_dx} < (W + 9)'(PAR_THRESH);
    assign par_y = {9'd0, mag_dy} < (W + 9)'(PAR_THRESH);
    assign out_x = (i_start_x < i_box_lo_x) || (i_box_hi_x < i_start_x);
    assign out_y = (i_start_y < i_box_lo_y) || (i_box_hi_y < i_start_y);

    // Divider operands and sideband for the next stage.
    always_comb begin
        n_num[LANE_LX] = {mag_lx, {FRAC_BITS{1'b0}}};
        n_num[LANE_HX] = {mag_hx, {FRAC_BITS{1'b0}}};
        n_num[LANE_LY] = {mag_ly, {FRAC_BITS{1'b0}}};
        n_num[LANE_HY] = {mag_hy, {FRAC_BITS{1'b0}}};
        n_den[LANE_LX] = mag_dx;
        n_den[LANE_HX] = mag_dx;
        n_den[LANE_LY] = mag_dy;
        n_den[LANE_HY] = mag_dy;
        n_side.neg[LANE_LX] = (f_lx[W] != dx[W]) && (mag_lx != '0);
        n_side.neg[LANE_HX] = (f_hx[W] != dx[W]) && (mag_hx != '0);
        n_side.neg[LANE_LY] = (f_ly[W] != dy[W]) && (mag_ly != '0);
        n_side.neg[LANE_HY] = (f_hy[W] != dy[W]) && (mag_hy != '0);
        n_side.par_x    = par_x;
        n_side.par_y    = par_y;
        n_side.par_miss = (par_x && out_x) || (par_y && out_y);
        n_side.max_frac = i_max_fraction;
    end

    // Valid bit is control state; the operands need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

>>> hw/rtl/aabb_div_pipe.sv
// ----------------------------------------------------------------------------
// aabb_div_pipe: pipelined restoring divider
// Four unsigned division lanes, one quotient bit per register stage, with the
// valid bit and sideband record carried stage by stage.
// ----------------------------------------------------------------------------
module aabb_div_pipe
    import aabb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int NW        = COORD_BITS + FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [LANES-1:0][NW-1:0]          i_num,
    input  logic [LANES-1:0][COORD_BITS-1:0]  i_den,
    input  t_side                             i_side,
    output logic                              o_valid,
    output logic [LANES-1:0][NW-1:0]          o_quo,
    output t_side                             o_side
);

    localparam int W = COORD_BITS;

    logic [NW-1:0]                          r_valid;
    logic [NW-1:0][LANES-1:0][W-1:0]        r_rem;
    logic [NW-1:0][LANES-1:0][NW-1:0]       r_quo;
    logic [NW-1:0][LANES-1:0][NW-1:0]       r_num;
    logic [NW-1:0][LANES-1:0][W-1:0]        r_den;
    t_side [NW-1:0]                         r_side;

    genvar k, l;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic                          p_valid;
            logic [LANES-1:0][W-1:0]       p_rem;
            logic [LANES-1:0][NW-1:0]      p_quo;
            logic [LANES-1:0][NW-1:0]      p_num;
            logic [LANES-1:0][W-1:0]       p_den;
            t_side                         p_side;
            logic [LANES-1:0][W-1:0]       n_rem;
            logic [LANES-1:0][NW-1:0]      n_quo;
            logic [LANES-1:0][NW-1:0]      n_num;

            // The first stage starts from a zero remainder.
            if (k == 0) begin : g_first
                assign p_valid = i_valid;
                assign p_rem   = '0;
                assign p_quo   = '0;
                assign p_num   = i_num;
                assign p_den   = i_den;
                assign p_side  = i_side;
            end else begin : g_next
                assign p_valid = r_valid[k-1];
                assign p_rem   = r_rem[k-1];
                assign p_quo   = r_quo[k-1];
                assign p_num   = r_num[k-1];
                assign p_den   = r_den[k-1];
                assign p_side  = r_side[k-1];
            end

            // One restoring step per lane: shift in a bit, subtract if it fits.
            for (l = 0; l < LANES; l++) begin : g_lane
                logic [W:0] trial;
                logic [W:0] diff;
                logic       fits;
                assign trial      = {p_rem[l], p_num[l][NW-1]};
                assign diff       = trial - {1'b0, p_den[l]};
                assign fits       = trial >= {1'b0, p_den[l]};
                assign n_rem[l]   = fits ? diff[W-1:0] : trial[W-1:0];
                assign n_quo[l]   = {p_quo[l][NW-2:0], fits};
                assign n_num[l]   = {p_num[l][NW-2:0], 1'b0};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= p_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_quo[k]  <= n_quo;
                    r_num[k]  <= n_num;
                    r_den[k]  <= p_den;
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

>>> hw/rtl/aabb_resolve.sv
// ----------------------------------------------------------------------------
// aabb_resolve: slab combination and result register
// Saturates and signs the four quotients, orders each axis, then merges the
// axes into entry fraction, normal and hit, ending in the output register.
// ----------------------------------------------------------------------------
module aabb_resolve
    import aabb_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int NW        = COORD_BITS + FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][NW-1:0]      i_quo,
    input  t_side                         i_side,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [FRAC_W-1:0]             o_fraction,
    output logic signed [1:0]             o_normal_x,
    output logic signed [1:0]             o_normal_y
);

    localparam int W = COORD_BITS;
    localparam logic [NW-1:0] LIM_POS = NW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [NW-1:0] LIM_NEG = NW'(64'd1 << (W - 1));
    localparam logic signed [1:0] NRM_NEG  = -2'sd1;
    localparam logic signed [1:0] NRM_POS  = 2'sd1;
    localparam logic signed [1:0] NRM_ZERO = 2'sd0;

    // Stage one: signed saturated fractions, ordered per axis.
    logic [LANES-1:0][W-1:0] t_val;
    logic signed [W-1:0]     ax_lo, ax_hi, ay_lo, ay_hi;
    logic                    swap_x, swap_y;

    genvar l;
    generate
        for (l = 0; l < LANES; l++) begin : g_sat
            logic [NW-1:0] lim;
            logic [W-1:0]  mag;
            assign lim      = i_side.neg[l] ? LIM_NEG : LIM_POS;
            assign mag      = (i_quo[l] > lim) ? lim[W-1:0] : i_quo[l][W-1:0];
            assign t_val[l] = i_side.neg[l] ? (~mag + W'(1)) : mag;
        end
    endgenerate

    assign ax_lo  = $signed(t_val[LANE_LX]);
    assign ax_hi  = $signed(t_val[LANE_HX]);
    assign ay_lo  = $signed(t_val[LANE_LY]);
    assign ay_hi  = $signed(t_val[LANE_HY]);
    assign swap_x = ax_lo > ax_hi;
    assign swap_y = ay_lo > ay_hi;

    logic                r_s1_valid;
    logic signed [W-1:0] r_enter_x, r_exit_x, r_enter_y, r_exit_y;
    logic                r_swap_x, r_swap_y;
    t_side               r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_enter_x <= swap_x ? ax_hi : ax_lo;
            r_exit_x  <= swap_x ? ax_lo : ax_hi;
            r_enter_y <= swap_y ? ay_hi : ay_lo;
            r_exit_y  <= swap_y ? ay_lo : ay_hi;
            r_swap_x  <= swap_x;
            r_swap_y  <= swap_y;
            r_s1_side <= i_side;
        end
    end

    // Stage two: merge x then y into entry/exit and decide the hit.
    logic                n_hit;
    logic [FRAC_W-1:0]   n_fraction;
    logic signed [1:0]   n_normal_x, n_normal_y;

    always_comb begin
        logic                have;
        logic                miss;
        logic signed [W-1:0] t_in, t_out;
        logic signed [1:0]   nx, ny;
        logic signed [W+31:0] t_ext;
        have  = 1'b0;
        miss  = r_s1_side.par_miss;
        t_in  = '0;
        t_out = '0;
        nx    = NRM_ZERO;
        ny    = NRM_ZERO;
        if (!r_s1_side.par_x) begin
            have  = 1'b1;
            t_in  = r_enter_x;
            t_out = r_exit_x;
            nx    = r_swap_x ? NRM_POS : NRM_NEG;
            if (t_in > t_out) begin
                miss = 1'b1;
            end
        end
        if (!r_s1_side.par_y) begin
            if (!have || r_enter_y > t_in) begin
                t_in = r_enter_y;
                nx   = NRM_ZERO;
                ny   = r_swap_y ? NRM_POS : NRM_NEG;
            end
            if (!have || r_exit_y < t_out) begin
                t_out = r_exit_y;
            end
            have = 1'b1;
            if (t_in > t_out) begin
                miss = 1'b1;
            end
        end
        t_ext = {{32{t_in[W-1]}}, t_in};
        n_hit = !miss && have && !t_in[W-1]
              && (t_ext <= $signed({(W + 1)'(0), r_s1_side.max_frac}));
        n_fraction = n_hit ? t_ext[FRAC_W-1:0] : '0;
        n_normal_x = n_hit ? nx : NRM_ZERO;
        n_normal_y = n_hit ? ny : NRM_ZERO;
    end

    logic              r_out_valid;
    logic              r_hit;
    logic [FRAC_W-1:0] r_fraction;
    logic signed [1:0] r_normal_x, r_normal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit      <= n_hit;
            r_fraction <= n_fraction;
            r_normal_x <= n_normal_x;
            r_normal_y <= n_normal_y;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hit      = r_hit;
    assign o_fraction = r_fraction;
    assign o_normal_x = r_normal_x;
    assign o_normal_y = r_normal_y;

endmodule
